/* rtl/c8ic_pkg.sv */
// c8ic_pkg: shared types and constants for the chip-8 instruction core
// no dependencies
`timescale 1ns / 1ps
package c8ic_pkg;

  localparam int MemBytesDefault   = 4096;
  localparam int StackDepthDefault = 16;
  localparam int RegCount          = 16;
  localparam logic [12:0] PcReset  = 13'h200;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StUndecoded = 3'd1;
  localparam logic [2:0] StPastEnd   = 3'd2;
  localparam logic [2:0] StOverflow  = 3'd3;
  localparam logic [2:0] StUnderflow = 3'd4;

  localparam logic OpLoad = 1'b0;
  localparam logic OpStep = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [15:0] key_mask;
    logic [3:0]  waited_key;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] next_pc;
    logic        clear_screen;
    logic        draw_request;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [3:0]  sprite_rows;
    logic [11:0] sprite_address;
  } out_req_t;

  // datapath commands
  typedef enum logic [3:0] {
    CmdNone,
    CmdLoad,
    CmdFetchHi,
    CmdFetchLo,
    CmdExec,
    CmdBcd,
    CmdStore,
    CmdLoadReg,
    CmdFinish
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] k;
  } ctl_t;

  typedef struct packed {
    logic       halted;
    logic       past_end;
    logic [1:0] multi;  // 0 none, 1 bcd, 2 store, 3 load
    logic [3:0] x;
  } sts_t;

  localparam logic [1:0] MultiNone  = 2'd0;
  localparam logic [1:0] MultiBcd   = 2'd1;
  localparam logic [1:0] MultiStore = 2'd2;
  localparam logic [1:0] MultiLoad  = 2'd3;

endpackage

/* rtl/c8ic_ctrl.sv */
// c8ic_ctrl: request sequencer for the chip-8 instruction core
// depends on c8ic_pkg
`timescale 1ns / 1ps
module c8ic_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  c8ic_pkg::in_req_t in_req,
  input  c8ic_pkg::sts_t  sts,
  output c8ic_pkg::ctl_t  ctl,
  output logic           busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_FHI, S_FLO, S_EXEC, S_DISP, S_MULTI, S_DONE
  } state_t;

  state_t     state_r;
  logic [3:0] k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= (in_req.opcode == c8ic_pkg::OpLoad) ? S_DONE : S_FHI;
          end
        end
        S_FHI: begin
          state_r <= (sts.halted || sts.past_end) ? S_DONE : S_FLO;
        end
        S_FLO: state_r <= S_EXEC;
        S_EXEC: state_r <= S_DISP;
        // multi-byte kind is registered by the execute cycle
        S_DISP: begin
          k_r     <= '0;
          state_r <= (sts.multi == c8ic_pkg::MultiNone) ? S_DONE : S_MULTI;
        end
        S_MULTI: begin
          k_r <= k_r + 4'd1;
          if ((sts.multi == c8ic_pkg::MultiBcd && k_r == 4'd2) ||
              (sts.multi != c8ic_pkg::MultiBcd && k_r == sts.x)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl.k = k_r;
    unique case (state_r)
      S_IDLE:  ctl.cmd = (start && in_req.opcode == c8ic_pkg::OpLoad) ? c8ic_pkg::CmdLoad
                                                                      : c8ic_pkg::CmdNone;
      S_FHI:   ctl.cmd = c8ic_pkg::CmdFetchHi;
      S_FLO:   ctl.cmd = c8ic_pkg::CmdFetchLo;
      S_EXEC:  ctl.cmd = c8ic_pkg::CmdExec;
      S_DISP:  ctl.cmd = c8ic_pkg::CmdNone;
      S_MULTI: begin
        unique case (sts.multi)
          c8ic_pkg::MultiBcd:   ctl.cmd = c8ic_pkg::CmdBcd;
          c8ic_pkg::MultiStore: ctl.cmd = c8ic_pkg::CmdStore;
          default:              ctl.cmd = c8ic_pkg::CmdLoadReg;
        endcase
      end
      S_DONE:  ctl.cmd = c8ic_pkg::CmdFinish;
      default: ctl.cmd = c8ic_pkg::CmdNone;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> state_r == S_IDLE) else $error("done not followed by idle");
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request accepted but not busy");
  a_multi_k: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MULTI && sts.multi == c8ic_pkg::MultiBcd |-> k_r <= 4'd2)
    else $error("bcd step out of range");

endmodule

/* rtl/c8ic_dp.sv */
// c8ic_dp: memory, registers, stack and execute logic of the chip-8 core
// depends on c8ic_pkg
`timescale 1ns / 1ps
module c8ic_dp #(
  parameter int MEMORY_BYTES = c8ic_pkg::MemBytesDefault,
  parameter int STACK_DEPTH  = c8ic_pkg::StackDepthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  c8ic_pkg::in_req_t in_req,
  input  c8ic_pkg::ctl_t    ctl,
  output c8ic_pkg::sts_t    sts,
  output logic              out_valid,
  output c8ic_pkg::out_req_t out_req
);

  localparam int SpW = $clog2(STACK_DEPTH + 1);
  localparam int SiW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [7:0]  mem_r [MEMORY_BYTES];
  logic [11:0] stk_r [STACK_DEPTH];
  logic [7:0]  v_r [c8ic_pkg::RegCount];
  logic [12:0] pc_r;
  logic [11:0] i_r;
  logic [SpW-1:0] sp_r;
  logic        halted_r;
  logic [2:0]  fault_r;
  c8ic_pkg::in_req_t req_r;
  logic [15:0] w_r;
  logic [7:0]  rd_r;
  logic [1:0]  multi_r;
  logic [7:0]  bcd_r;
  c8ic_pkg::out_req_t res_r;
  c8ic_pkg::out_req_t res_nxt;
  logic        ov_r;

  // memory port
  logic        mwe;
  logic [11:0] mwa, mra;
  logic [7:0]  mwd;
  logic [11:0] ik;
  logic [7:0]  bcd_digit;
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_rem;
  logic [14:0] bcd_prod;
  logic [3:0]  bcd_t;

  assign ik = i_r + {8'd0, ctl.k};

  // hundreds by compare, tens by reciprocal multiply
  assign bcd_h    = (bcd_r >= 8'd200) ? 2'd2 : ((bcd_r >= 8'd100) ? 2'd1 : 2'd0);
  assign bcd_rem  = bcd_r - ((bcd_h == 2'd2) ? 8'd200 : ((bcd_h == 2'd1) ? 8'd100 : 8'd0));
  assign bcd_prod = {7'd0, bcd_rem} * 15'd205;
  assign bcd_t    = bcd_prod[14:11];

  always_comb begin
    unique case (ctl.k[1:0])
      2'd0:    bcd_digit = {6'd0, bcd_h};
      2'd1:    bcd_digit = {4'd0, bcd_t};
      default: bcd_digit = bcd_rem - 8'({4'd0, bcd_t} * 8'd10);
    endcase
  end

  always_comb begin
    mwe = 1'b0;
    mwa = ik;
    mwd = v_r[ctl.k];
    mra = ik;
    if (ctl.cmd == c8ic_pkg::CmdLoad) begin
      mwe = 1'b1;
      mwa = in_req.load_address;
      mwd = in_req.load_byte;
    end else if (ctl.cmd == c8ic_pkg::CmdStore) begin
      mwe = 1'b1;
    end else if (ctl.cmd == c8ic_pkg::CmdBcd) begin
      mwe = 1'b1;
      mwd = bcd_digit;
    end
    if (ctl.cmd == c8ic_pkg::CmdFetchHi) mra = pc_r[11:0];
    else if (ctl.cmd == c8ic_pkg::CmdFetchLo) mra = pc_r[11:0] + 12'd1;
  end

  always_ff @(posedge clk) begin
    if (mwe && 32'(mwa) < MEMORY_BYTES) mem_r[mwa] <= mwd;
    rd_r <= (32'(mra) < MEMORY_BYTES) ? mem_r[mra] : 8'd0;
  end

  // decode fields
  logic [3:0]  x, y, n;
  logic [7:0]  kk, vx, vy;
  logic [11:0] nnn;
  logic [15:0] w;
  assign w   = {w_r[15:8], rd_r};
  assign x   = w[11:8];
  assign y   = w[7:4];
  assign n   = w[3:0];
  assign kk  = w[7:0];
  assign nnn = w[11:0];
  assign vx  = v_r[x];
  assign vy  = v_r[y];

  logic [2:0]  st;
  logic [12:0] nxt;
  logic        wr_x, wr_f, fbit, clr, drw, push, pop, set_i;
  logic [7:0]  xval;
  logic [11:0] ival;
  logic [1:0]  multi;
  logic [8:0]  sum;
  logic        pressed;
  logic [12:0] pc2;

  assign sum     = {1'b0, vx} + {1'b0, vy};
  assign pressed = (vx < 8'd16) && req_r.key_mask[vx[3:0]];
  assign pc2     = pc_r + 13'd2;

  always_comb begin
    st = c8ic_pkg::StOk; nxt = pc2; wr_x = 1'b0; wr_f = 1'b0; fbit = 1'b0;
    clr = 1'b0; drw = 1'b0; push = 1'b0; pop = 1'b0; set_i = 1'b0;
    xval = '0; ival = '0; multi = c8ic_pkg::MultiNone;
    unique case (w[15:12])
      4'h0: begin
        if (w == 16'h00E0) clr = 1'b1;
        else if (w == 16'h00EE) begin
          if (sp_r == '0) st = c8ic_pkg::StUnderflow;
          else begin
            pop = 1'b1;
            nxt = {1'b0, stk_r[SiW'(sp_r - SpW'(1))]} + 13'd2;
          end
        end else st = c8ic_pkg::StUndecoded;
      end
      4'h1: nxt = {1'b0, nnn};
      4'h2: begin
        if (32'(sp_r) >= STACK_DEPTH) st = c8ic_pkg::StOverflow;
        else begin push = 1'b1; nxt = {1'b0, nnn}; end
      end
      4'h3: if (vx == kk) nxt = pc_r + 13'd4;
      4'h4: if (vx != kk) nxt = pc_r + 13'd4;
      4'h5: begin
        if (n != 4'd0) st = c8ic_pkg::StUndecoded;
        else if (vx == vy) nxt = pc_r + 13'd4;
      end
      4'h6: begin wr_x = 1'b1; xval = kk; end
      4'h7: begin wr_x = 1'b1; xval = vx + kk; end
      4'h8: begin
        case (n)
          4'h0: begin wr_x = 1'b1; xval = vy; end
          4'h1: begin wr_x = 1'b1; xval = vx | vy; end
          4'h2: begin wr_x = 1'b1; xval = vx & vy; end
          4'h3: begin wr_x = 1'b1; xval = vx ^ vy; end
          4'h4: begin wr_x = 1'b1; wr_f = 1'b1; xval = sum[7:0]; fbit = sum[8]; end
          4'h5: begin wr_x = 1'b1; wr_f = 1'b1; xval = vx - vy; fbit = vx > vy; end
          4'h6: begin wr_x = 1'b1; wr_f = 1'b1; xval = vx >> 1; fbit = vx[0]; end
          4'h7: begin wr_x = 1'b1; wr_f = 1'b1; xval = vy - vx; fbit = vy > vx; end
          4'hE: begin wr_x = 1'b1; wr_f = 1'b1; xval = vx << 1; fbit = vx[7]; end
          default: st = c8ic_pkg::StUndecoded;
        endcase
      end
      4'h9: begin
        if (n != 4'd0) st = c8ic_pkg::StUndecoded;
        else if (vx != vy) nxt = pc_r + 13'd4;
      end
      4'hA: begin set_i = 1'b1; ival = nnn; end
      4'hB: nxt = {5'd0, v_r[0]} + {1'b0, nnn};
      4'hC: ;
      4'hD: drw = 1'b1;
      4'hE: begin
        if (kk == 8'h9E) begin if (pressed) nxt = pc_r + 13'd4; end
        else if (kk == 8'hA1) begin if (!pressed) nxt = pc_r + 13'd4; end
        else st = c8ic_pkg::StUndecoded;
      end
      default: begin
        case (kk)
          8'h07, 8'h15, 8'h18, 8'h29: ;
          8'h0A: begin wr_x = 1'b1; xval = {4'd0, req_r.waited_key}; end
          8'h1E: begin set_i = 1'b1; ival = i_r + {4'd0, vx}; end
          8'h33: multi = c8ic_pkg::MultiBcd;
          8'h55: multi = c8ic_pkg::MultiStore;
          8'h65: multi = c8ic_pkg::MultiLoad;
          default: st = c8ic_pkg::StUndecoded;
        endcase
      end
    endcase
  end

  // result register contents
  always_comb begin
    res_nxt = res_r;
    unique case (ctl.cmd)
      c8ic_pkg::CmdLoad: begin
        res_nxt = '0;
        res_nxt.next_pc = pc_r;
      end
      c8ic_pkg::CmdFetchHi: begin
        res_nxt = '0;
        res_nxt.next_pc = pc_r;
        if (halted_r) res_nxt.status = fault_r;
        else if (32'(pc_r) > MEMORY_BYTES - 2) res_nxt.status = c8ic_pkg::StPastEnd;
      end
      c8ic_pkg::CmdExec: begin
        res_nxt = '0;
        res_nxt.status = st;
        res_nxt.next_pc = pc_r;
        if (st == c8ic_pkg::StOk) begin
          res_nxt.next_pc = nxt;
          res_nxt.clear_screen = clr;
          if (drw) begin
            res_nxt.draw_request = 1'b1;
            res_nxt.draw_x = vx;
            res_nxt.draw_y = vy;
            res_nxt.sprite_rows = n;
            res_nxt.sprite_address = i_r;
          end
        end
      end
      default: ;
    endcase
  end

  logic ld_pend_r;
  logic [3:0] ld_k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < c8ic_pkg::RegCount; r++) v_r[r] <= '0;
      pc_r <= c8ic_pkg::PcReset; i_r <= '0; sp_r <= '0;
      halted_r <= 1'b0; fault_r <= c8ic_pkg::StOk;
      ov_r <= 1'b0; multi_r <= c8ic_pkg::MultiNone;
      ld_pend_r <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      res_r <= res_nxt;
      ld_pend_r <= (ctl.cmd == c8ic_pkg::CmdLoadReg);
      ld_k_r <= ctl.k;
      if (ld_pend_r) v_r[ld_k_r] <= rd_r;
      unique case (ctl.cmd)
        c8ic_pkg::CmdLoad: req_r <= in_req;
        c8ic_pkg::CmdNone: if (!ld_pend_r) req_r <= in_req;
        c8ic_pkg::CmdFetchHi: begin
          multi_r <= c8ic_pkg::MultiNone;
          if (!halted_r && 32'(pc_r) > MEMORY_BYTES - 2) begin
            halted_r <= 1'b1; fault_r <= c8ic_pkg::StPastEnd;
          end
        end
        c8ic_pkg::CmdFetchLo: w_r[15:8] <= rd_r;
        c8ic_pkg::CmdExec: begin
          if (st != c8ic_pkg::StOk) begin
            halted_r <= 1'b1; fault_r <= st;
          end else begin
            pc_r <= nxt;
            // flag write wins when x is vf
            if (wr_x && !(wr_f && x == 4'hF)) v_r[x] <= xval;
            if (wr_f) v_r[15] <= {7'd0, fbit};
            if (set_i) i_r <= ival;
            if (push) begin
              stk_r[SiW'(sp_r)] <= pc_r[11:0];
              sp_r <= sp_r + SpW'(1);
            end
            if (pop) sp_r <= sp_r - SpW'(1);
            multi_r <= multi;
            bcd_r <= vx;
            w_r[7:0] <= rd_r;
          end
        end
        c8ic_pkg::CmdFinish: ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign sts.halted   = halted_r;
  assign sts.past_end = 32'(pc_r) > MEMORY_BYTES - 2;
  assign sts.multi    = multi_r;
  assign sts.x        = w_r[11:8];
  assign out_valid    = ov_r;
  assign out_req      = res_r;

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= STACK_DEPTH) else $error("stack pointer out of range");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r) else $error("halt cleared");
  a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r && $past(halted_r) |-> $stable(pc_r)) else $error("pc moved while halted");

endmodule

/* rtl/chip8_instruction_core_top.sv */
// chip8_instruction_core_top: chip-8 instruction core, one request at a time
// a load writes one byte; a step fetches high and low byte, executes, then writes bcd
// digits or stores/loads registers; a halted or past-end step ends after the fetch
// a new request is taken only when idle; the memory port does one byte per cycle
// reset: synchronous active-low; registers cleared, pc 0x200, memory and stack undefined
// results are strobed for one cycle on out_valid; the receiver cannot stall
`timescale 1ns / 1ps
module chip8_instruction_core_top #(
  parameter int MEMORY_BYTES = c8ic_pkg::MemBytesDefault,
  parameter int STACK_DEPTH  = c8ic_pkg::StackDepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  c8ic_pkg::in_req_t  in_req,
  output logic               out_valid,
  output c8ic_pkg::out_req_t out_req
);

  c8ic_pkg::ctl_t ctl;
  c8ic_pkg::sts_t sts;

  c8ic_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_req(in_req),
    .sts(sts), .ctl(ctl), .busy(busy)
  );

  c8ic_dp #(.MEMORY_BYTES(MEMORY_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .ctl(ctl), .sts(sts),
    .out_valid(out_valid), .out_req(out_req)
  );

endmodule
